// ----- src/lmfp_pkg.sv -----
// ----------------------------------------------------------------------------
// lmfp_pkg: shared definitions for the LED matrix frame player
// Widths, command codes, sequencer states and the structs passed between
// the controller, the frame/dwell stores and the pixel output stage.
// ----------------------------------------------------------------------------
`default_nettype none

package lmfp_pkg;

    // Number of stored frames
    localparam int FRAMES    = 128;
    localparam int FRAME_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int ROWS      = 8;
    localparam int ROW_W     = 3;
    localparam int FADDR_W   = FRAME_W + ROW_W;
    localparam int FDEPTH    = FRAMES * ROWS;

    // Item field widths
    localparam int MODE_W    = 3;
    localparam int FNUM_W    = 7;
    localparam int BITS_W    = 8;
    localparam int DWELL_W   = 15;
    localparam int COUNT_W   = 16;
    localparam int POS_W     = 6;
    localparam int FSHOWN_W  = 7;

    // Command codes
    typedef enum logic [MODE_W-1:0] {
        MODE_TICK      = 3'd0,
        MODE_FRAME_ROW = 3'd1,
        MODE_DWELL     = 3'd2,
        MODE_STILL_ROW = 3'd3,
        MODE_RUN       = 3'd4,
        MODE_STOP      = 3'd5,
        MODE_CLEAR     = 3'd6
    } mode_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TICK,
        ST_SRCH_RD,
        ST_SRCH_CHK
    } state_t;

    // Store access from the controller
    typedef struct packed {
        logic                fr_we;
        logic [FADDR_W-1:0]  fr_waddr;
        logic [BITS_W-1:0]   fr_wdata;
        logic [FADDR_W-1:0]  fr_raddr;
        logic                dw_we;
        logic [FRAME_W-1:0]  dw_waddr;
        logic [DWELL_W-1:0]  dw_wdata;
        logic [FRAME_W-1:0]  dw_raddr;
    } mem_req_t;

    // Registered read data from the stores
    typedef struct packed {
        logic [BITS_W-1:0]   fr_rdata;
        logic [DWELL_W-1:0]  dw_rdata;
    } mem_rsp_t;

    // One scanned pixel handed to the output stage
    typedef struct packed {
        logic                load;
        logic [BITS_W-1:0]   line;
        logic [POS_W-1:0]    pos;
        logic [FRAME_W-1:0]  frame;
        logic                run;
    } tick_t;

endpackage

`default_nettype wire

// ----- src/lmfp_if.sv -----
// ----------------------------------------------------------------------------
// lmfp_if: channel interfaces of the LED matrix frame player
// Command channel (items in) and pixel channel (results out), each with
// valid/ready; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
`default_nettype none

interface lmfp_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [6:0]  frame_number;
    logic [2:0]  row_number;
    logic [7:0]  row_bits;
    logic [14:0] dwell;

    modport source (output valid, output mode, output frame_number,
                    output row_number, output row_bits, output dwell,
                    input ready);
    modport sink   (input valid, input mode, input frame_number,
                    input row_number, input row_bits, input dwell,
                    output ready);
endinterface

interface lmfp_pix_if;
    logic        valid;
    logic        ready;
    logic [7:0]  row_drive;
    logic [7:0]  column_drive;
    logic        pixel_on;
    logic [6:0]  frame_shown;
    logic        playing;
    logic        scan_done;

    modport source (output valid, output row_drive, output column_drive,
                    output pixel_on, output frame_shown, output playing,
                    output scan_done, input ready);
    modport sink   (input valid, input row_drive, input column_drive,
                    input pixel_on, input frame_shown, input playing,
                    input scan_done, output ready);
endinterface

`default_nettype wire

// ----- src/lmfp_store.sv -----
// ----------------------------------------------------------------------------
// lmfp_store: frame row memory and dwell memory
// One write and one registered read port per memory.
// ----------------------------------------------------------------------------
`default_nettype none

module lmfp_store (
    input  wire logic               clk,
    input  wire lmfp_pkg::mem_req_t req,
    output lmfp_pkg::mem_rsp_t      rsp
);

    logic [lmfp_pkg::BITS_W-1:0]  frame_mem [lmfp_pkg::FDEPTH];
    logic [lmfp_pkg::DWELL_W-1:0] dwell_mem [lmfp_pkg::FRAMES];
    logic [lmfp_pkg::BITS_W-1:0]  fr_rdata_reg;
    logic [lmfp_pkg::DWELL_W-1:0] dw_rdata_reg;

    // Frame rows
    always_ff @(posedge clk)
    begin
        if (req.fr_we)
        begin
            frame_mem[req.fr_waddr] <= req.fr_wdata;
        end
        fr_rdata_reg <= frame_mem[req.fr_raddr];
    end

    // Dwell counts
    always_ff @(posedge clk)
    begin
        if (req.dw_we)
        begin
            dwell_mem[req.dw_waddr] <= req.dw_wdata;
        end
        dw_rdata_reg <= dwell_mem[req.dw_raddr];
    end

    assign rsp.fr_rdata = fr_rdata_reg;
    assign rsp.dw_rdata = dw_rdata_reg;

endmodule

`default_nettype wire

// ----- src/lmfp_pixel.sv -----
// ----------------------------------------------------------------------------
// lmfp_pixel: pixel decode and output register
// Turns a scanned row line and position into row/column drive and holds
// the result until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module lmfp_pixel (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire lmfp_pkg::tick_t tick,
    input  wire logic            flip_rows,
    output logic                 out_free,
    lmfp_pix_if.source           pix
);

    logic       valid_reg, valid_next;
    logic [7:0] row_drive_reg, column_drive_reg;
    logic       pixel_on_reg, playing_reg, scan_done_reg;
    logic [lmfp_pkg::FSHOWN_W-1:0] frame_shown_reg;

    logic [2:0] row_idx, col_idx, row_line, col_line;
    logic       lit;
    logic [7:0] row_drive_d, column_drive_d;

    // Decode position into drive lines
    always_comb
    begin
        row_idx        = tick.pos[5:3];
        col_idx        = tick.pos[2:0];
        lit            = tick.line[col_idx];
        row_line       = flip_rows ? ~row_idx : row_idx;
        col_line       = flip_rows ? col_idx : ~col_idx;
        row_drive_d    = lit ? (8'd1 << row_line) : 8'd0;
        column_drive_d = lit ? ~(8'd1 << col_line) : 8'hFF;
    end

    assign out_free   = !valid_reg || pix.ready;
    assign valid_next = tick.load || (valid_reg && !pix.ready);

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (tick.load)
        begin
            row_drive_reg    <= row_drive_d;
            column_drive_reg <= column_drive_d;
            pixel_on_reg     <= lit;
            frame_shown_reg  <= lmfp_pkg::FSHOWN_W'(tick.frame);
            playing_reg      <= tick.run;
            scan_done_reg    <= (tick.pos == {lmfp_pkg::POS_W{1'b1}});
        end
    end

    assign pix.valid        = valid_reg;
    assign pix.row_drive    = row_drive_reg;
    assign pix.column_drive = column_drive_reg;
    assign pix.pixel_on     = pixel_on_reg;
    assign pix.frame_shown  = frame_shown_reg;
    assign pix.playing      = playing_reg;
    assign pix.scan_done    = scan_done_reg;

endmodule

`default_nettype wire

// ----- src/lmfp_ctrl.sv -----
// ----------------------------------------------------------------------------
// lmfp_ctrl: command sequencer and frame search
// Decodes command items, runs the store clearing sweep, scans pixels and
// walks the dwell memory for the next frame with one shared comparator.
// ----------------------------------------------------------------------------
`default_nettype none

module lmfp_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    lmfp_cmd_if.sink                cmd,
    input  wire logic               out_free,
    input  wire lmfp_pkg::mem_rsp_t rsp,
    output lmfp_pkg::mem_req_t      req,
    output lmfp_pkg::tick_t         tick
);

    localparam int FRAME_W = lmfp_pkg::FRAME_W;
    localparam int FADDR_W = lmfp_pkg::FADDR_W;
    localparam logic [FADDR_W-1:0] CLR_LAST = FADDR_W'(lmfp_pkg::FDEPTH - 1);
    localparam logic [FRAME_W-1:0] FRM_LAST = FRAME_W'(lmfp_pkg::FRAMES - 1);

    lmfp_pkg::state_t state_reg, state_next;
    logic                          run_reg, run_next;
    logic [FRAME_W-1:0]            cur_reg, cur_next;
    logic [FRAME_W-1:0]            f_reg, f_next;
    logic [lmfp_pkg::COUNT_W-1:0]  cnt_reg, cnt_next;
    logic [lmfp_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic [FADDR_W-1:0]            clr_reg, clr_next;
    logic [7:0]                    still_reg [8];
    logic [7:0]                    still_next [8];

    logic                          acc;
    logic                          fnum_ok;
    logic [FRAME_W-1:0]            fnum;
    logic [FRAME_W-1:0]            f_inc;
    logic [lmfp_pkg::COUNT_W-1:0]  cnt_inc;
    logic [lmfp_pkg::COUNT_W-1:0]  cmp_a, cmp_b;
    logic                          cmp_ge;
    logic                          scan_end;

    assign cmd.ready = (state_reg == lmfp_pkg::ST_IDLE);
    assign acc       = cmd.valid && cmd.ready;
    assign fnum_ok   = (32'(cmd.frame_number) < 32'(lmfp_pkg::FRAMES));
    assign fnum      = FRAME_W'(cmd.frame_number);
    assign f_inc     = (f_reg == FRM_LAST) ? '0 : f_reg + 1'b1;
    assign cnt_inc   = cnt_reg + 1'b1;
    assign scan_end  = (pos_reg == {lmfp_pkg::POS_W{1'b1}}) && run_reg;

    // Shared comparator: scan count against dwell, or dwell nonzero test
    always_comb
    begin
        if (state_reg == lmfp_pkg::ST_SRCH_CHK)
        begin
            cmp_a = lmfp_pkg::COUNT_W'(rsp.dw_rdata);
            cmp_b = lmfp_pkg::COUNT_W'(1);
        end
        else
        begin
            cmp_a = cnt_inc;
            cmp_b = lmfp_pkg::COUNT_W'(rsp.dw_rdata);
        end
        cmp_ge = (cmp_a >= cmp_b);
    end

    // Next state and outputs
    always_comb
    begin
        state_next = state_reg;
        run_next   = run_reg;
        cur_next   = cur_reg;
        f_next     = f_reg;
        cnt_next   = cnt_reg;
        pos_next   = pos_reg;
        clr_next   = clr_reg;
        still_next = still_reg;

        req.fr_we    = 1'b0;
        req.fr_waddr = {fnum, cmd.row_number};
        req.fr_wdata = cmd.row_bits;
        req.fr_raddr = {cur_reg, pos_reg[5:3]};
        req.dw_we    = 1'b0;
        req.dw_waddr = fnum;
        req.dw_wdata = cmd.dwell;
        req.dw_raddr = cur_reg;

        tick.load  = 1'b0;
        tick.line  = run_reg ? rsp.fr_rdata : still_reg[pos_reg[5:3]];
        tick.pos   = pos_reg;
        tick.frame = cur_reg;
        tick.run   = run_reg;

        unique case (state_reg)
            lmfp_pkg::ST_CLEAR:
            begin
                // Zero one frame row per cycle, dwell on each eighth
                req.fr_we    = 1'b1;
                req.fr_waddr = clr_reg;
                req.fr_wdata = '0;
                req.dw_we    = (clr_reg[2:0] == 3'd0);
                req.dw_waddr = clr_reg[FADDR_W-1:3];
                req.dw_wdata = '0;
                clr_next     = clr_reg + 1'b1;
                if (clr_reg == CLR_LAST)
                begin
                    state_next = lmfp_pkg::ST_IDLE;
                end
            end

            lmfp_pkg::ST_IDLE:
            begin
                if (acc)
                begin
                    case (lmfp_pkg::mode_t'(cmd.mode))
                        lmfp_pkg::MODE_TICK:
                        begin
                            state_next = lmfp_pkg::ST_TICK;
                        end
                        lmfp_pkg::MODE_FRAME_ROW:
                        begin
                            if (fnum_ok)
                            begin
                                req.fr_we                   = 1'b1;
                                still_next[cmd.row_number] = cmd.row_bits;
                            end
                        end
                        lmfp_pkg::MODE_DWELL:
                        begin
                            req.dw_we = fnum_ok;
                        end
                        lmfp_pkg::MODE_STILL_ROW:
                        begin
                            still_next[cmd.row_number] = cmd.row_bits;
                        end
                        lmfp_pkg::MODE_RUN:
                        begin
                            run_next = 1'b1;
                        end
                        lmfp_pkg::MODE_STOP:
                        begin
                            run_next = 1'b0;
                        end
                        lmfp_pkg::MODE_CLEAR:
                        begin
                            run_next   = 1'b0;
                            clr_next   = '0;
                            state_next = lmfp_pkg::ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = lmfp_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            lmfp_pkg::ST_TICK:
            begin
                // Row data and dwell are now registered; wait for a free slot
                if (out_free)
                begin
                    tick.load  = 1'b1;
                    pos_next   = pos_reg + 1'b1;
                    state_next = lmfp_pkg::ST_IDLE;
                    if (scan_end)
                    begin
                        if (cmp_ge)
                        begin
                            cnt_next   = '0;
                            f_next     = cur_reg;
                            state_next = lmfp_pkg::ST_SRCH_RD;
                        end
                        else
                        begin
                            cnt_next = cnt_inc;
                        end
                    end
                end
            end

            lmfp_pkg::ST_SRCH_RD:
            begin
                req.dw_raddr = f_inc;
                f_next       = f_inc;
                state_next   = lmfp_pkg::ST_SRCH_CHK;
            end

            lmfp_pkg::ST_SRCH_CHK:
            begin
                if (cmp_ge)
                begin
                    cur_next   = f_reg;
                    state_next = lmfp_pkg::ST_IDLE;
                end
                else if (f_reg == cur_reg)
                begin
                    run_next   = 1'b0;
                    state_next = lmfp_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = lmfp_pkg::ST_SRCH_RD;
                end
            end

            default:
            begin
                state_next = lmfp_pkg::ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lmfp_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Player state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b1;
            cur_reg   <= '0;
            f_reg     <= '0;
            cnt_reg   <= '0;
            pos_reg   <= '0;
            clr_reg   <= '0;
            still_reg <= '{default: '0};
        end
        else
        begin
            run_reg   <= run_next;
            cur_reg   <= cur_next;
            f_reg     <= f_next;
            cnt_reg   <= cnt_next;
            pos_reg   <= pos_next;
            clr_reg   <= clr_next;
            still_reg <= still_next;
        end
    end

    // Checks
    a_tick_to_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && cmd.mode == lmfp_pkg::MODE_TICK) |=> state_reg == lmfp_pkg::ST_TICK)
        else $error("tick transfer did not start a scan step");

    a_clear_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && cmd.mode == lmfp_pkg::MODE_CLEAR)
            |=> (!run_reg && state_reg == lmfp_pkg::ST_CLEAR && clr_reg == '0))
        else $error("clear did not stop playback and start the sweep");

    a_search_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lmfp_pkg::ST_SRCH_CHK && rsp.dw_rdata != '0)
            |=> cur_reg == $past(f_reg))
        else $error("search did not move to the frame with nonzero dwell");

    a_pos_moves_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        tick.load |=> pos_reg == $past(pos_reg) + 1'b1)
        else $error("scan position did not advance with a pixel");

endmodule

`default_nettype wire

// ----- src/led_matrix_frame_player.sv -----
// ----------------------------------------------------------------------------
// led_matrix_frame_player: 8x8 LED matrix frame player
// Scans one pixel per tick command from a stored frame sequence or a still
// image; command items load frames, dwells and control playback.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake     Payload
// cmd       in   valid/ready   mode, frame_number, row_number, row_bits, dwell
// pix       out  valid/ready   row_drive, column_drive, pixel_on, frame_shown,
//                              playing, scan_done
// cfg       in   cfg_we        cfg_data (flip_rows)
//
// Commands other than tick and clear finish as they are taken. A tick
// first reads the store, then decodes into the output register.
// At the end of a scan that exhausts the dwell, the frame search reads the
// dwell memory one frame at a time, read then check, up to FRAMES frames (one
// read port). After reset and after a clear, a sweep zeroes all FRAMES*8
// rows (1024) of the stores, during which cmd.ready is low. Config writes
// are taken at any time. A stalled pix sink holds one result; further
// commands are still taken and the next tick waits in its decode step.
// ----------------------------------------------------------------------------
`default_nettype none

module led_matrix_frame_player (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  cfg_we,
    input  wire logic  cfg_data,
    lmfp_cmd_if.sink   cmd,
    lmfp_pix_if.source pix
);

    logic               flip_reg;
    logic               out_free;
    lmfp_pkg::mem_req_t req;
    lmfp_pkg::mem_rsp_t rsp;
    lmfp_pkg::tick_t    tick;

    // Mirror select register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flip_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            flip_reg <= cfg_data;
        end
    end

    lmfp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .out_free (out_free),
        .rsp      (rsp),
        .req      (req),
        .tick     (tick)
    );

    lmfp_store u_store (
        .clk (clk),
        .req (req),
        .rsp (rsp)
    );

    lmfp_pixel u_pixel (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick),
        .flip_rows (flip_reg),
        .out_free  (out_free),
        .pix       (pix)
    );

endmodule

`default_nettype wire

// ----- tb/sv/tb_led_matrix_frame_player.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_led_matrix_frame_player: self-checking bench for the LED matrix player
// Drives command transfers with random gaps and predicts every pixel result
// from an internal copy of the frame, dwell and still-image stores. Checks
// each pixel transfer field by field. Walks both flip_rows settings.
// ----------------------------------------------------------------------------
module tb_led_matrix_frame_player;
    import lmfp_pkg::*;

    localparam logic [2:0] MODE_UNUSED = 3'd7;
    localparam int LIMIT_CYCLES   = 400000;
    localparam int SETTLE_CYCLES  = 1400;   // clear sweep plus a full frame search
    localparam int LONG_HOLD      = 400;
    localparam int HOLD_AFTER     = 600;    // command count that triggers the long hold
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_ITEMS    = 200;

    typedef struct packed {
        logic [2:0]  mode;
        logic [6:0]  frame_number;
        logic [2:0]  row_number;
        logic [7:0]  row_bits;
        logic [14:0] dwell;
    } cmd_item_t;

    typedef struct packed {
        logic [7:0] row_drive;
        logic [7:0] column_drive;
        logic       pixel_on;
        logic [6:0] frame_shown;
        logic       playing;
        logic       scan_done;
    } pixel_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_data;

    lmfp_cmd_if cmd_ch ();
    lmfp_pix_if pix_ch ();

    led_matrix_frame_player u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .cmd      (cmd_ch),
        .pix      (pix_ch)
    );

    // Player state as the bench sees it
    logic [7:0]  frame_mem [0:FDEPTH-1];
    logic [14:0] dwell_mem [0:FRAMES-1];
    logic [7:0]  still_mem [0:ROWS-1];
    logic        run_q;
    logic [6:0]  cur_frame;
    logic [15:0] scans;
    logic [5:0]  pos;
    logic        flip_q;

    cmd_item_t cmds_to_send [$];
    pixel_t    pixels_due [$];

    int  errors;
    int  cycles;
    int  cmds_sent;
    int  cmds_queued;
    int  ticks_checked;
    int  frame_changes;
    int  player_stops;
    bit  cmd_fired;
    bit  steady;

    // driver / receiver pacing
    int        send_gap;
    int        drv_calm;
    int        recv_gap;
    int        rcv_calm;
    int        hold_left;
    bit        hold_done;
    cmd_item_t nxt;
    cmd_item_t got_cmd;
    pixel_t    got_px;
    pixel_t    want_px;
    bit        has_px;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Apply one command to the bench state; a tick yields the pixel it shows
    task automatic scan_command(input cmd_item_t c, output bit yields, output pixel_t px);
        logic [2:0] r;
        logic [2:0] col;
        logic [2:0] rline;
        logic [2:0] cline;
        logic [7:0] line;
        logic       lit;
        logic [6:0] probe;
        bit         found;
        yields = 1'b0;
        px = '0;
        case (c.mode)
            MODE_TICK:
            begin
                r = pos[5:3];
                col = pos[2:0];
                line = run_q ? frame_mem[{cur_frame, r}] : still_mem[r];
                lit = line[col];
                rline = flip_q ? 3'd7 - r : r;
                cline = flip_q ? col : 3'd7 - col;
                px.row_drive = lit ? (8'd1 << rline) : 8'd0;
                px.column_drive = lit ? ~(8'd1 << cline) : 8'hFF;
                px.pixel_on = lit;
                px.frame_shown = cur_frame;
                px.playing = run_q;
                px.scan_done = (pos == 6'd63);
                yields = 1'b1;
                pos = pos + 6'd1;
                // end of a full scan: count it against the dwell, maybe move on
                if (px.scan_done && run_q)
                begin
                    scans = scans + 16'd1;
                    if (scans >= {1'b0, dwell_mem[cur_frame]})
                    begin
                        scans = '0;
                        probe = cur_frame;
                        found = 1'b0;
                        for (int k = 0; k < FRAMES && !found; k++)
                        begin
                            probe = (probe == 7'(FRAMES - 1)) ? 7'd0 : probe + 7'd1;
                            if (dwell_mem[probe] != 0)
                                found = 1'b1;
                        end
                        if (found)
                        begin
                            if (probe != cur_frame)
                                frame_changes++;
                            cur_frame = probe;
                        end
                        else
                        begin
                            run_q = 1'b0;
                            player_stops++;
                        end
                    end
                end
            end
            MODE_FRAME_ROW:
            begin
                if (c.frame_number < FRAMES)
                begin
                    frame_mem[{c.frame_number, c.row_number}] = c.row_bits;
                    still_mem[c.row_number] = c.row_bits;
                end
            end
            MODE_DWELL:
            begin
                if (c.frame_number < FRAMES)
                    dwell_mem[c.frame_number] = c.dwell;
            end
            MODE_STILL_ROW: still_mem[c.row_number] = c.row_bits;
            MODE_RUN:       run_q = 1'b1;
            MODE_STOP:      run_q = 1'b0;
            MODE_CLEAR:
            begin
                run_q = 1'b0;
                foreach (frame_mem[i]) frame_mem[i] = '0;
                foreach (dwell_mem[i]) dwell_mem[i] = '0;
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            errors++;
        end
    endtask

    task automatic queue_cmd(input logic [2:0] m, input logic [6:0] f, input logic [2:0] r,
                             input logic [7:0] b, input logic [14:0] d);
        cmd_item_t c;
        c = '{mode: m, frame_number: f, row_number: r, row_bits: b, dwell: d};
        cmds_to_send.push_back(c);
        cmds_queued++;
    endtask

    // Let everything drain, then give the block time to finish silent work
    task automatic wait_idle(input int settle);
        do
            @(posedge clk);
        while (cmds_to_send.size() != 0 || cmd_ch.valid || pixels_due.size() != 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_flip(input logic v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        flip_q = v;
    endtask

    // Mostly well-formed playlists: load frames, set dwells, run, then tick
    task automatic queue_random_phase(input int budget);
        int         start;
        int         n;
        int         burst;
        logic [6:0] base;
        logic [6:0] fr;
        start = cmds_queued;
        while (cmds_queued - start < budget)
        begin
            if ($urandom_range(0, 7) == 0)
                queue_cmd(MODE_CLEAR, 7'($urandom), 3'($urandom), 8'($urandom), 15'($urandom));
            n = $urandom_range(1, 4);
            base = ($urandom_range(0, 3) == 0) ? 7'd126 : 7'($urandom);
            fr = base;
            for (int k = 0; k < n; k++)
            begin
                for (int r = 0; r < ROWS; r++)
                    queue_cmd(MODE_FRAME_ROW, fr, 3'(r), 8'($urandom), 15'($urandom));
                // sometimes a full-width dwell first so every dwell bit toggles, then a short one
                if ($urandom_range(0, 3) == 0)
                    queue_cmd(MODE_DWELL, fr, 3'($urandom), 8'($urandom), 15'($urandom));
                queue_cmd(MODE_DWELL, fr, 3'($urandom), 8'($urandom),
                          ($urandom_range(0, 5) == 0) ? 15'd0 : 15'($urandom_range(1, 2)));
                fr = fr + 7'($urandom_range(1, 40));
            end
            if ($urandom_range(0, 5) != 0)
                queue_cmd(MODE_RUN, 7'($urandom), 3'($urandom), 8'($urandom), 15'($urandom));
            burst = $urandom_range(40, 260);
            for (int t = 0; t < burst; t++)
            begin
                if ($urandom_range(0, 13) != 0)
                    queue_cmd(MODE_TICK, 7'($urandom), 3'($urandom), 8'($urandom), 15'($urandom));
                else
                begin
                    case ($urandom_range(0, 5))
                        0: queue_cmd(MODE_STILL_ROW, 7'($urandom), 3'($urandom), 8'($urandom),
                                     15'($urandom));
                        1: queue_cmd(MODE_FRAME_ROW, 7'($urandom), 3'($urandom), 8'($urandom),
                                     15'($urandom));
                        2: queue_cmd(MODE_DWELL, 7'($urandom), 3'($urandom), 8'($urandom),
                                     15'($urandom_range(0, 2)));
                        3: queue_cmd(MODE_STOP, 7'($urandom), 3'($urandom), 8'($urandom),
                                     15'($urandom));
                        4: queue_cmd(MODE_RUN, 7'($urandom), 3'($urandom), 8'($urandom),
                                     15'($urandom));
                        default: queue_cmd(MODE_UNUSED, 7'($urandom), 3'($urandom),
                                           8'($urandom), 15'($urandom));
                    endcase
                end
            end
        end
    endtask

    // Command driver: holds an item until its transfer, random gaps between
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (drv_calm > 0)
                drv_calm--;
            else if ($urandom_range(0, 299) == 0)
                drv_calm = $urandom_range(40, 160);
            if (!(cmd_ch.valid && !cmd_fired))
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    cmd_ch.valid <= 1'b0;
                end
                else if (!steady && drv_calm == 0 && $urandom_range(0, 5) == 0)
                begin
                    send_gap = $urandom_range(0, 13);
                    cmd_ch.valid <= 1'b0;
                end
                else if (cmds_to_send.size() > 0)
                begin
                    nxt = cmds_to_send.pop_front();
                    cmd_ch.mode <= nxt.mode;
                    cmd_ch.frame_number <= nxt.frame_number;
                    cmd_ch.row_number <= nxt.row_number;
                    cmd_ch.row_bits <= nxt.row_bits;
                    cmd_ch.dwell <= nxt.dwell;
                    cmd_ch.valid <= 1'b1;
                end
                else
                    cmd_ch.valid <= 1'b0;
            end
        end
    end

    // Pixel receiver: short random stalls plus one long hold to back up the block
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rcv_calm > 0)
                rcv_calm--;
            else if ($urandom_range(0, 299) == 0)
                rcv_calm = $urandom_range(40, 160);
            if (hold_left > 0)
            begin
                hold_left--;
                pix_ch.ready <= 1'b0;
            end
            else if (!hold_done && cmds_sent >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD - 1;
                pix_ch.ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                pix_ch.ready <= 1'b0;
            end
            else if (!steady && rcv_calm == 0 && $urandom_range(0, 4) == 0)
            begin
                recv_gap = $urandom_range(0, 13);
                pix_ch.ready <= 1'b0;
            end
            else
                pix_ch.ready <= 1'b1;
        end
    end

    // Sample both channels: check pixel transfers, predict from command transfers
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles, %0d pixels still pending",
                     cycles, pixels_due.size());
            $display("Regression FAIL");
            $finish;
        end
        else if (rst_n)
        begin
            if (pix_ch.valid && pix_ch.ready)
            begin
                if (pixels_due.size() == 0)
                begin
                    $error("pixel transfer with no pixel pending");
                    errors++;
                end
                else
                begin
                    want_px = pixels_due.pop_front();
                    got_px = {pix_ch.row_drive, pix_ch.column_drive, pix_ch.pixel_on,
                              pix_ch.frame_shown, pix_ch.playing, pix_ch.scan_done};
                    check_field("row_drive", 16'(want_px.row_drive), 16'(got_px.row_drive));
                    check_field("column_drive", 16'(want_px.column_drive),
                                16'(got_px.column_drive));
                    check_field("pixel_on", 16'(want_px.pixel_on), 16'(got_px.pixel_on));
                    check_field("frame_shown", 16'(want_px.frame_shown),
                                16'(got_px.frame_shown));
                    check_field("playing", 16'(want_px.playing), 16'(got_px.playing));
                    check_field("scan_done", 16'(want_px.scan_done), 16'(got_px.scan_done));
                    ticks_checked++;
                end
            end
            cmd_fired = cmd_ch.valid && cmd_ch.ready;
            if (cmd_fired)
            begin
                cmds_sent++;
                got_cmd = {cmd_ch.mode, cmd_ch.frame_number, cmd_ch.row_number,
                           cmd_ch.row_bits, cmd_ch.dwell};
                scan_command(got_cmd, has_px, want_px);
                if (has_px)
                    pixels_due.push_back(want_px);
            end
        end
    end

    initial
    begin
        // known values on every input from time zero
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.mode = MODE_TICK;
        cmd_ch.frame_number = '0;
        cmd_ch.row_number = '0;
        cmd_ch.row_bits = '0;
        cmd_ch.dwell = '0;
        pix_ch.ready = 1'b0;
        foreach (frame_mem[i]) frame_mem[i] = '0;
        foreach (dwell_mem[i]) dwell_mem[i] = '0;
        foreach (still_mem[i]) still_mem[i] = '0;
        run_q = 1'b1;
        cur_frame = '0;
        scans = '0;
        pos = '0;
        flip_q = 1'b0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        write_flip(1'b0);

        // directed: field extremes, every command, stop/run/clear, unused mode
        queue_cmd(MODE_TICK, 7'd0, 3'd0, 8'd0, 15'd0);
        queue_cmd(MODE_FRAME_ROW, 7'd0, 3'd0, 8'hFF, 15'd0);
        queue_cmd(MODE_FRAME_ROW, 7'd127, 3'd7, 8'h80, 15'h7FFF);
        queue_cmd(MODE_DWELL, 7'd0, 3'd0, 8'd0, 15'h7FFF);
        queue_cmd(MODE_DWELL, 7'd127, 3'd7, 8'hFF, 15'd1);
        queue_cmd(MODE_STILL_ROW, 7'd0, 3'd7, 8'h01, 15'd0);
        repeat (3) queue_cmd(MODE_TICK, 7'd0, 3'd0, 8'd0, 15'd0);
        queue_cmd(MODE_STOP, 7'd0, 3'd0, 8'd0, 15'd0);
        repeat (2) queue_cmd(MODE_TICK, 7'd0, 3'd0, 8'd0, 15'd0);
        queue_cmd(MODE_RUN, 7'd0, 3'd0, 8'd0, 15'd0);
        queue_cmd(MODE_TICK, 7'd0, 3'd0, 8'd0, 15'd0);
        queue_cmd(MODE_DWELL, 7'd5, 3'd0, 8'd0, 15'd0);
        queue_cmd(MODE_UNUSED, 7'd127, 3'd7, 8'hFF, 15'h7FFF);
        queue_cmd(MODE_CLEAR, 7'd0, 3'd0, 8'd0, 15'd0);
        queue_cmd(MODE_TICK, 7'd0, 3'd0, 8'd0, 15'd0);
        queue_cmd(MODE_RUN, 7'd0, 3'd0, 8'd0, 15'd0);
        repeat (2) queue_cmd(MODE_TICK, 7'd0, 3'd0, 8'd0, 15'd0);
        wait_idle(SETTLE_CYCLES);

        // random phases, alternating flip_rows; the last one runs without idling
        for (int ph = 1; ph <= RANDOM_PHASES; ph++)
        begin
            write_flip(1'(ph % 2));
            if (ph == RANDOM_PHASES)
            begin
                @(posedge clk);
                steady = 1'b1;
            end
            queue_random_phase(PHASE_ITEMS);
            wait_idle((ph == RANDOM_PHASES) ? 60 : SETTLE_CYCLES);
        end

        $display("Sent %0d commands, checked %0d pixels over both flip_rows settings",
                 cmds_sent, ticks_checked);
        $display("Saw %0d frame changes and %0d stops for lack of a nonzero dwell",
                 frame_changes, player_stops);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
src/lmfp_pkg.sv
src/lmfp_if.sv
src/lmfp_store.sv
src/lmfp_pixel.sv
src/lmfp_ctrl.sv
src/led_matrix_frame_player.sv
tb/sv/tb_led_matrix_frame_player.sv
